// ===== hdl/fbre_pkg.sv =====
// Package for the framebuffer raster engine.
// Holds command codes, sequencer states, default sizes and a sign-extension helper.
// No dependencies.
package fbre_pkg;

    // Default geometry and circle limit.
    localparam int DEF_SCREEN_WORDS  = 8192;
    localparam int DEF_WORDS_PER_ROW = 32;
    localparam int DEF_MAX_RADIUS    = 181;

    // Width of the internal signed coordinates.
    localparam int CW = 19;

    // Command codes.
    localparam logic [3:0] KIND_CLEAR  = 4'd0;
    localparam logic [3:0] KIND_DARK   = 4'd1;
    localparam logic [3:0] KIND_INVERT = 4'd2;
    localparam logic [3:0] KIND_COLOR  = 4'd3;
    localparam logic [3:0] KIND_PIXEL  = 4'd4;
    localparam logic [3:0] KIND_LINE   = 4'd5;
    localparam logic [3:0] KIND_RECT   = 4'd6;
    localparam logic [3:0] KIND_CIRCLE = 4'd7;
    localparam logic [3:0] KIND_READ   = 4'd8;

    localparam logic [15:0] COLOR_BLACK = 16'hFFFF;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_START,
        S_FILL,
        S_INV_RD,
        S_INV_WR,
        S_PIXEL,
        S_PIX_WR,
        S_HSPAN,
        S_VSPAN,
        S_LINE,
        S_RECT_ROW,
        S_CIRC_ROW,
        S_SQRT,
        S_READ,
        S_READ_WAIT,
        S_DONE
    } state_t;

    // Sign-extend a 16-bit field to the coordinate width.
    function automatic logic signed [CW-1:0] sext16(input logic signed [15:0] v);
        return CW'(v);
    endfunction

endpackage

// ===== hdl/fbre_if.sv =====
// Channel interfaces for the framebuffer raster engine.
// fbre_cmd_if carries command requests, fbre_res_if carries results. No dependencies.
interface fbre_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic signed [15:0] x_first;
    logic signed [15:0] y_first;
    logic signed [15:0] x_second;
    logic signed [15:0] y_second;
    logic signed [15:0] radius;
    logic signed [15:0] color_value;
    logic [12:0] word_address;

    modport source (output valid, kind, x_first, y_first, x_second, y_second, radius,
                    color_value, word_address, input ready);
    modport sink   (input valid, kind, x_first, y_first, x_second, y_second, radius,
                    color_value, word_address, output ready);
endinterface

interface fbre_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic [3:0]  done_kind;

    modport source (output valid, read_data, done_kind, input ready);
    modport sink   (input valid, read_data, done_kind, output ready);
endinterface

// ===== hdl/framebuffer_raster_engine_top.sv =====
// Framebuffer raster engine: command sequencer around one frame memory.
// Depends on fbre_pkg and the fbre_cmd_if / fbre_res_if interfaces.
//
//   channel | direction | moves
//   cmd     | in        | one drawing or read command request
//   res     | out       | one result (read_data, done_kind) per command
//
// Each pixel is a read-modify-write of the single-port frame memory: the word
// is read, then written back in S_PIX_WR; off-screen pixels make no access. Clear
// and dark write every word once, invert reads and writes back every word. A
// circle row first runs the bit-per-cycle square root. After reset a clearing
// pass over every word runs before the first command is taken. A stalled result
// holds in the output register; the engine stalls only when a second result is ready.
module framebuffer_raster_engine_top #(
    parameter int SCREEN_WORDS  = fbre_pkg::DEF_SCREEN_WORDS,
    parameter int WORDS_PER_ROW = fbre_pkg::DEF_WORDS_PER_ROW,
    parameter int MAX_RADIUS    = fbre_pkg::DEF_MAX_RADIUS
) (
    input  logic clk,
    input  logic rst_n,
    fbre_cmd_if.sink   cmd,
    fbre_res_if.source res
);
    import fbre_pkg::*;

    localparam int AW = $clog2(SCREEN_WORDS);
    localparam logic signed [CW-1:0] SCR_W = CW'(WORDS_PER_ROW * 16);
    localparam logic signed [CW-1:0] SCR_H = CW'(SCREEN_WORDS / WORDS_PER_ROW);
    localparam logic signed [CW-1:0] X_LAST = CW'(WORDS_PER_ROW * 16 - 1);
    localparam logic signed [CW-1:0] Y_LAST = CW'(SCREEN_WORDS / WORDS_PER_ROW - 1);
    localparam logic [AW-1:0] LAST_WORD = AW'(SCREEN_WORDS - 1);

    // Frame memory.
    logic [15:0] mem [SCREEN_WORDS];
    logic [15:0] rdata_reg;
    logic        mem_re, mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0] mem_wdata;

    // Sequencer and command registers.
    state_t state_reg, state_next, ret_reg, ret_next;
    logic [3:0]  kind_reg, kind_next;
    logic signed [15:0] xf_reg, xf_next, yf_reg, yf_next, xs_reg, xs_next, ys_reg, ys_next;
    logic signed [15:0] rad_reg, rad_next, cv_reg, cv_next;
    logic [12:0] wa_reg, wa_next;
    logic [15:0] color_reg, color_next, fill_reg, fill_next, rd_reg, rd_next;
    logic [AW-1:0] idx_reg, idx_next, paddr_reg, paddr_next;
    logic [3:0]  pbit_reg, pbit_next;
    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next, ex_reg, ex_next, ey_reg, ey_next;
    logic signed [CW-1:0] lx_reg, lx_next, ly_reg, ly_next, la_reg, la_next, lb_reg, lb_next;
    logic signed [CW-1:0] dx_reg, dx_next, dy_reg, dy_next, err_reg, err_next;
    logic signed [CW-1:0] row_reg, row_next, rowend_reg, rowend_next;
    logic signed [CW-1:0] rx1_reg, rx1_next, rx2_reg, rx2_next;
    logic signed [8:0]  cdy_reg, cdy_next;
    logic [15:0] rsq_reg, rsq_next, sqn_reg, sqn_next, sqr_reg, sqr_next, sqb_reg, sqb_next;

    // Result register.
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic [3:0]  out_kind_reg;
    logic        load_out;

    // Memory port: one access per cycle, registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            idx_reg       <= '0;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            color_reg <= color_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        ret_reg <= ret_next;     kind_reg <= kind_next;
        xf_reg <= xf_next;       yf_reg <= yf_next;
        xs_reg <= xs_next;       ys_reg <= ys_next;
        rad_reg <= rad_next;     cv_reg <= cv_next;
        wa_reg <= wa_next;       fill_reg <= fill_next;
        rd_reg <= rd_next;       paddr_reg <= paddr_next;
        pbit_reg <= pbit_next;   cx_reg <= cx_next;
        cy_reg <= cy_next;       ex_reg <= ex_next;
        ey_reg <= ey_next;       lx_reg <= lx_next;
        ly_reg <= ly_next;       la_reg <= la_next;
        lb_reg <= lb_next;       dx_reg <= dx_next;
        dy_reg <= dy_next;       err_reg <= err_next;
        row_reg <= row_next;     rowend_reg <= rowend_next;
        rx1_reg <= rx1_next;     rx2_reg <= rx2_next;
        cdy_reg <= cdy_next;     rsq_reg <= rsq_next;
        sqn_reg <= sqn_next;     sqr_reg <= sqr_next;
        sqb_reg <= sqb_next;
        if (load_out)
        begin
            out_data_reg <= rd_reg;
            out_kind_reg <= kind_reg;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.read_data = out_data_reg;
    assign res.done_kind = out_kind_reg;
    assign cmd.ready     = (state_reg == S_IDLE);

    // Next state, pixel requests and span setup.
    always_comb
    begin
        state_t st_after, span_ret;
        logic plot_go, hs_go;
        logic signed [CW-1:0] px, py, hs_xa, hs_xb, hs_y;
        logic signed [CW-1:0] x1, y1, x2, y2, ymin, ymax, dd;
        logic [31:0] prod, wa32;
        logic signed [17:0] dsq;
        logic [15:0] trial;

        state_next = state_reg;  ret_next = ret_reg;  kind_next = kind_reg;
        xf_next = xf_reg;  yf_next = yf_reg;  xs_next = xs_reg;  ys_next = ys_reg;
        rad_next = rad_reg;  cv_next = cv_reg;  wa_next = wa_reg;
        color_next = color_reg;  fill_next = fill_reg;  rd_next = rd_reg;
        idx_next = idx_reg;  paddr_next = paddr_reg;  pbit_next = pbit_reg;
        cx_next = cx_reg;  cy_next = cy_reg;  ex_next = ex_reg;  ey_next = ey_reg;
        lx_next = lx_reg;  ly_next = ly_reg;  la_next = la_reg;  lb_next = lb_reg;
        dx_next = dx_reg;  dy_next = dy_reg;  err_next = err_reg;
        row_next = row_reg;  rowend_next = rowend_reg;
        rx1_next = rx1_reg;  rx2_next = rx2_reg;
        cdy_next = cdy_reg;  rsq_next = rsq_reg;
        sqn_next = sqn_reg;  sqr_next = sqr_reg;  sqb_next = sqb_reg;
        mem_re = 1'b0;  mem_we = 1'b0;  mem_addr = '0;  mem_wdata = '0;
        load_out = 1'b0;
        st_after = state_reg;
        plot_go = 1'b0;  px = '0;  py = '0;
        hs_go = 1'b0;  hs_xa = '0;  hs_xb = '0;  hs_y = '0;
        x1 = '0;  y1 = '0;  x2 = '0;  y2 = '0;  ymin = '0;  ymax = '0;  dd = '0;
        prod = '0;  dsq = '0;  trial = '0;
        wa32 = 32'(wa_reg);

        // Spans return to the row loop of a rectangle or circle; other spans finish the command.
        if (kind_reg == KIND_RECT)
        begin
            span_ret = S_RECT_ROW;
        end
        else if (kind_reg == KIND_CIRCLE)
        begin
            span_ret = S_CIRC_ROW;
        end
        else
        begin
            span_ret = S_DONE;
        end

        unique case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;  mem_addr = idx_reg;  mem_wdata = '0;
                idx_next = idx_reg + 1'b1;
                st_after = (idx_reg == LAST_WORD) ? S_IDLE : S_INIT;
            end
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    kind_next = cmd.kind;
                    xf_next = cmd.x_first;   yf_next = cmd.y_first;
                    xs_next = cmd.x_second;  ys_next = cmd.y_second;
                    rad_next = cmd.radius;   cv_next = cmd.color_value;
                    wa_next = cmd.word_address;
                    rd_next = '0;
                    st_after = S_START;
                end
            end
            S_START:
            begin
                idx_next = '0;
                x1 = sext16(xf_reg);  y1 = sext16(yf_reg);
                x2 = sext16(xs_reg);  y2 = sext16(ys_reg);
                priority case (kind_reg)
                    KIND_CLEAR:
                    begin
                        color_next = COLOR_BLACK;  fill_next = '0;  st_after = S_FILL;
                    end
                    KIND_DARK:
                    begin
                        color_next = '0;  fill_next = '1;  st_after = S_FILL;
                    end
                    KIND_INVERT:
                    begin
                        color_next = ~color_reg;  st_after = S_INV_RD;
                    end
                    KIND_COLOR:
                    begin
                        color_next = cv_reg;  st_after = S_DONE;
                    end
                    KIND_PIXEL:  st_after = S_PIXEL;
                    KIND_LINE:
                    begin
                        // Order the endpoints by x.
                        if (x2 < x1)
                        begin
                            x1 = sext16(xs_reg);  y1 = sext16(ys_reg);
                            x2 = sext16(xf_reg);  y2 = sext16(yf_reg);
                        end
                        if (x1 == x2)
                        begin
                            ymin = (y1 < y2) ? y1 : y2;
                            ymax = (y1 < y2) ? y2 : y1;
                            if (x1 < 0 || x1 >= SCR_W)
                            begin
                                st_after = S_DONE;
                            end
                            else
                            begin
                                cx_next = x1;
                                cy_next = (ymin < 0) ? '0 : ymin;
                                ey_next = (ymax > Y_LAST) ? Y_LAST : ymax;
                                st_after = S_VSPAN;
                            end
                        end
                        else if (y1 == y2)
                        begin
                            hs_go = 1'b1;  hs_xa = x1;  hs_xb = x2;  hs_y = y1;
                        end
                        else
                        begin
                            lx_next = x1;  ly_next = y1;
                            dx_next = x2 - x1;  dy_next = y2 - y1;
                            la_next = '0;  lb_next = '0;  err_next = '0;
                            st_after = S_LINE;
                        end
                    end
                    KIND_RECT:
                    begin
                        rx1_next = (x1 > x2) ? x2 : x1;
                        rx2_next = (x1 > x2) ? x1 : x2;
                        row_next = (y1 < 0) ? '0 : y1;
                        rowend_next = (y2 > Y_LAST) ? Y_LAST : y2;
                        st_after = S_RECT_ROW;
                    end
                    KIND_CIRCLE:
                    begin
                        if (rad_reg < 16'sd1 || rad_reg > 16'(MAX_RADIUS))
                        begin
                            st_after = S_DONE;
                        end
                        else
                        begin
                            rsq_next = 16'(rad_reg[7:0] * rad_reg[7:0]);
                            cdy_next = -9'(rad_reg);
                            st_after = S_CIRC_ROW;
                        end
                    end
                    KIND_READ:   st_after = (wa32 < 32'(SCREEN_WORDS)) ? S_READ : S_DONE;
                    default:     st_after = S_DONE;
                endcase
            end
            S_FILL:
            begin
                mem_we = 1'b1;  mem_addr = idx_reg;  mem_wdata = fill_reg;
                idx_next = idx_reg + 1'b1;
                st_after = (idx_reg == LAST_WORD) ? S_DONE : S_FILL;
            end
            S_INV_RD:
            begin
                mem_re = 1'b1;  mem_addr = idx_reg;  st_after = S_INV_WR;
            end
            S_INV_WR:
            begin
                mem_we = 1'b1;  mem_addr = idx_reg;  mem_wdata = ~rdata_reg;
                idx_next = idx_reg + 1'b1;
                st_after = (idx_reg == LAST_WORD) ? S_DONE : S_INV_RD;
            end
            S_PIXEL:
            begin
                plot_go = 1'b1;  px = sext16(xf_reg);  py = sext16(yf_reg);
                st_after = S_DONE;
            end
            S_PIX_WR:
            begin
                mem_we = 1'b1;  mem_addr = paddr_reg;
                if (color_reg == COLOR_BLACK)
                begin
                    mem_wdata = rdata_reg | (16'd1 << pbit_reg);
                end
                else
                begin
                    mem_wdata = rdata_reg & ~(16'd1 << pbit_reg);
                end
                st_after = ret_reg;
            end
            S_HSPAN:
            begin
                if (cx_reg <= ex_reg)
                begin
                    plot_go = 1'b1;  px = cx_reg;  py = cy_reg;
                    cx_next = cx_reg + 1'b1;
                    st_after = S_HSPAN;
                end
                else
                begin
                    st_after = span_ret;
                end
            end
            S_VSPAN:
            begin
                if (cy_reg <= ey_reg)
                begin
                    plot_go = 1'b1;  px = cx_reg;  py = cy_reg;
                    cy_next = cy_reg + 1'b1;
                    st_after = S_VSPAN;
                end
                else
                begin
                    st_after = S_DONE;
                end
            end
            S_LINE:
            begin
                // Error-term walk; y steps toward the sign of dy.
                if (la_reg <= dx_reg &&
                    ((dy_reg > 0) ? (lb_reg <= dy_reg) : (lb_reg >= dy_reg)))
                begin
                    plot_go = 1'b1;  px = lx_reg + la_reg;  py = ly_reg + lb_reg;
                    if (err_reg < 0)
                    begin
                        la_next = la_reg + 1'b1;
                        err_next = (dy_reg > 0) ? err_reg + dy_reg : err_reg - dy_reg;
                    end
                    else
                    begin
                        lb_next = (dy_reg > 0) ? lb_reg + 1'b1 : lb_reg - 1'b1;
                        err_next = err_reg - dx_reg;
                    end
                    st_after = S_LINE;
                end
                else
                begin
                    st_after = S_DONE;
                end
            end
            S_RECT_ROW:
            begin
                if (row_reg <= rowend_reg)
                begin
                    hs_go = 1'b1;  hs_xa = rx1_reg;  hs_xb = rx2_reg;  hs_y = row_reg;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    st_after = S_DONE;
                end
            end
            S_CIRC_ROW:
            begin
                if (CW'(cdy_reg) < sext16(rad_reg))
                begin
                    dsq = cdy_reg * cdy_reg;
                    sqn_next = rsq_reg - dsq[15:0];
                    sqr_next = '0;
                    sqb_next = 16'h4000;
                    st_after = S_SQRT;
                end
                else
                begin
                    st_after = S_DONE;
                end
            end
            S_SQRT:
            begin
                // One result bit per cycle, then fill the row.
                if (sqb_reg != '0)
                begin
                    trial = sqr_reg + sqb_reg;
                    if (sqn_reg >= trial)
                    begin
                        sqn_next = sqn_reg - trial;
                        sqr_next = (sqr_reg >> 1) + sqb_reg;
                    end
                    else
                    begin
                        sqr_next = sqr_reg >> 1;
                    end
                    sqb_next = sqb_reg >> 2;
                    st_after = S_SQRT;
                end
                else
                begin
                    dd = CW'(sqr_reg);
                    hs_go = 1'b1;
                    hs_xa = sext16(xf_reg) - dd;
                    hs_xb = sext16(xf_reg) + dd;
                    hs_y  = sext16(yf_reg) + CW'(cdy_reg);
                    cdy_next = cdy_reg + 1'b1;
                end
            end
            S_READ:
            begin
                mem_re = 1'b1;  mem_addr = wa32[AW-1:0];  st_after = S_READ_WAIT;
            end
            S_READ_WAIT:
            begin
                rd_next = rdata_reg;  st_after = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    load_out = 1'b1;  st_after = S_IDLE;
                end
            end
            default: st_after = S_IDLE;
        endcase

        // Span entry: drop rows off screen, clip the x range.
        if (hs_go)
        begin
            if (hs_y < 0 || hs_y >= SCR_H)
            begin
                st_after = span_ret;
            end
            else
            begin
                cx_next = (hs_xa < 0) ? '0 : hs_xa;
                ex_next = (hs_xb > X_LAST) ? X_LAST : hs_xb;
                cy_next = hs_y;
                st_after = S_HSPAN;
            end
        end

        // Pixel request: read the word now, write it back next cycle.
        state_next = st_after;
        if (plot_go && px >= 0 && px < SCR_W && py >= 0 && py < SCR_H)
        begin
            prod = 32'(py) * 32'(WORDS_PER_ROW) + 32'(px >>> 4);
            if (prod < 32'(SCREEN_WORDS))
            begin
                mem_re = 1'b1;
                mem_addr = prod[AW-1:0];
                paddr_next = prod[AW-1:0];
                pbit_next = px[3:0];
                ret_next = st_after;
                state_next = S_PIX_WR;
            end
        end
    end

endmodule

// ===== hdl/fbre_checker.sv =====
// Port-level checks for the framebuffer raster engine, bound to the top level.
// Depends on fbre_pkg and framebuffer_raster_engine_top.
module fbre_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [15:0] res_read_data,
    input logic [3:0]  res_done_kind
);
    import fbre_pkg::*;

    // A stalled result keeps its valid.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_read_data) && $stable(res_done_kind))
        else $error("result payload changed while stalled");

    // Only a read word command returns data.
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_done_kind != KIND_READ |-> res_read_data == 16'd0)
        else $error("nonzero data on a result that is not a read");

    // Commands are taken one at a time.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while another is running");

endmodule

bind framebuffer_raster_engine_top fbre_port_checker u_fbre_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_read_data (res.read_data),
    .res_done_kind (res.done_kind)
);

// ===== tb/fbre_checker.sv =====
// Result checker for the framebuffer raster engine testbench.
// Watches both channels, keeps its own framebuffer and drawing color, and compares results.
// Depends on fbre_pkg and the fbre_cmd_if / fbre_res_if interfaces.
module fbre_checker
    import fbre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fbre_cmd_if  cmd,
    fbre_res_if  res,
    output int   fail_count,
    output int   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCR_W = DEF_WORDS_PER_ROW * 16;
    localparam int SCR_H = DEF_SCREEN_WORDS / DEF_WORDS_PER_ROW;

    typedef struct packed {
        logic [15:0] read_data;
        logic [3:0]  done_kind;
    } result_t;

    logic [15:0] frame_words [DEF_SCREEN_WORDS];
    logic [15:0] pen_color;
    result_t     awaited_results [$];

    initial
    begin
        foreach (frame_words[i])
            frame_words[i] = '0;
        pen_color  = '0;
        fail_count = 0;
    end

    assign pending_count = awaited_results.size();

    // Plot one pixel; off-screen pixels are dropped.
    function automatic void plot_pixel(int x, int y);
        int addr;
        if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H)
            return;
        addr = y * DEF_WORDS_PER_ROW + x / 16;
        if (pen_color == COLOR_BLACK)
            frame_words[addr][x % 16] = 1'b1;
        else
            frame_words[addr][x % 16] = 1'b0;
    endfunction

    function automatic void fill_row(int xa, int xb, int y);
        if (y < 0 || y >= SCR_H)
            return;
        if (xa < 0)
            xa = 0;
        if (xb > SCR_W - 1)
            xb = SCR_W - 1;
        for (int i = xa; i <= xb; i++)
            plot_pixel(i, y);
    endfunction

    function automatic void fill_column(int x, int ya, int yb);
        if (x < 0 || x >= SCR_W)
            return;
        if (ya < 0)
            ya = 0;
        if (yb > SCR_H - 1)
            yb = SCR_H - 1;
        for (int i = ya; i <= yb; i++)
            plot_pixel(x, i);
    endfunction

    // Line: order by x, straight cases first, then the error-term walk.
    function automatic void trace_line(int x1, int y1, int x2, int y2);
        int t;
        int dx;
        int dy;
        int a;
        int b;
        int err;
        a = 0;
        b = 0;
        err = 0;
        if (x2 < x1)
        begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
        end
        if (x1 == x2)
        begin
            if (y1 < y2)
                fill_column(x1, y1, y2);
            else
                fill_column(x1, y2, y1);
            return;
        end
        if (y1 == y2)
        begin
            fill_row(x1, x2, y1);
            return;
        end
        dx = x2 - x1;
        dy = y2 - y1;
        if (dy > 0)
        begin
            while (a <= dx && b <= dy)
            begin
                plot_pixel(x1 + a, y1 + b);
                if (err < 0)
                begin
                    a++;
                    err += dy;
                end
                else
                begin
                    b++;
                    err -= dx;
                end
            end
        end
        else
        begin
            while (a <= dx && b >= dy)
            begin
                plot_pixel(x1 + a, y1 + b);
                if (err < 0)
                begin
                    a++;
                    err -= dy;
                end
                else
                begin
                    b--;
                    err -= dx;
                end
            end
        end
    endfunction

    function automatic void fill_box(int x1, int y1, int x2, int y2);
        int t;
        if (x1 > x2)
        begin
            t = x1; x1 = x2; x2 = t;
        end
        if (y1 < 0)
            y1 = 0;
        if (y2 > SCR_H - 1)
            y2 = SCR_H - 1;
        for (int i = y1; i <= y2; i++)
            fill_row(x1, x2, i);
    endfunction

    function automatic int floor_sqrt(int v);
        int s;
        s = 0;
        while ((s + 1) * (s + 1) <= v)
            s++;
        return s;
    endfunction

    // Filled disk without its bottom row; oversized radii draw nothing.
    function automatic void fill_disk(int x, int y, int r);
        int half_w;
        if ((r < 0 ? -r : r) > DEF_MAX_RADIUS)
            return;
        for (int dy = -r; dy < r; dy++)
        begin
            half_w = floor_sqrt(r * r - dy * dy);
            fill_row(x - half_w, x + half_w, y + dy);
        end
    endfunction

    // Apply one command request and return the result it should produce.
    function automatic result_t run_command();
        result_t r;
        r.read_data = '0;
        r.done_kind = cmd.kind;
        case (cmd.kind)
            KIND_CLEAR:
            begin
                foreach (frame_words[i])
                    frame_words[i] = '0;
                pen_color = COLOR_BLACK;
            end
            KIND_DARK:
            begin
                foreach (frame_words[i])
                    frame_words[i] = 16'hFFFF;
                pen_color = '0;
            end
            KIND_INVERT:
            begin
                foreach (frame_words[i])
                    frame_words[i] = ~frame_words[i];
                pen_color = ~pen_color;
            end
            KIND_COLOR:  pen_color = cmd.color_value;
            KIND_PIXEL:  plot_pixel(int'(cmd.x_first), int'(cmd.y_first));
            KIND_LINE:   trace_line(int'(cmd.x_first), int'(cmd.y_first),
                                    int'(cmd.x_second), int'(cmd.y_second));
            KIND_RECT:   fill_box(int'(cmd.x_first), int'(cmd.y_first),
                                  int'(cmd.x_second), int'(cmd.y_second));
            KIND_CIRCLE: fill_disk(int'(cmd.x_first), int'(cmd.y_first), int'(cmd.radius));
            KIND_READ:   r.read_data = frame_words[cmd.word_address];
            default:     ;
        endcase
        return r;
    endfunction

    // Predict on each accepted request, compare each accepted result.
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n)
        begin
            if (cmd.valid && cmd.ready)
                awaited_results.push_back(run_command());
            if (res.valid && res.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: done_kind %0d read_data %h",
                           res.done_kind, res.read_data);
                    fail_count++;
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    if (res.done_kind !== exp_r.done_kind)
                    begin
                        $error("done_kind expected %0d actual %0d",
                               exp_r.done_kind, res.done_kind);
                        fail_count++;
                    end
                    if (res.read_data !== exp_r.read_data)
                    begin
                        $error("read_data expected %h actual %h",
                               exp_r.read_data, res.read_data);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the framebuffer raster engine testbench: clock, reset, stimulus and verdict.
// Depends on fbre_pkg, fbre_cmd_if / fbre_res_if, fbre_checker and the engine itself.
module tb_top;
    import fbre_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1030;
    localparam int IDLE_LIMIT   = 600000;

    typedef struct {
        logic [3:0]         kind;
        logic signed [15:0] xf;
        logic signed [15:0] yf;
        logic signed [15:0] xs;
        logic signed [15:0] ys;
        logic signed [15:0] rad;
        logic signed [15:0] color;
        logic [12:0]        addr;
    } command_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   sent_count;
    int   idle_cycles;
    bit   steady_mode;

    fbre_cmd_if cmd_ch();
    fbre_res_if res_ch();

    framebuffer_raster_engine_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    fbre_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_ch),
        .res           (res_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Mostly short gaps, now and then a long one; none in steady stretches.
    function automatic int pick_gap();
        int p;
        if (steady_mode)
            return 0;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // Result side stalls at random.
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= (pick_gap() == 0);
    end

    // Watchdog on cycles in which no request or result moves.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Drive one command request and hold it until accepted.
    task automatic send(command_t c);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        cmd_ch.kind         <= c.kind;
        cmd_ch.x_first      <= c.xf;
        cmd_ch.y_first      <= c.yf;
        cmd_ch.x_second     <= c.xs;
        cmd_ch.y_second     <= c.ys;
        cmd_ch.radius       <= c.rad;
        cmd_ch.color_value  <= c.color;
        cmd_ch.word_address <= c.addr;
        cmd_ch.valid        <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sent_count++;
    endtask

    function automatic command_t make_cmd(logic [3:0] k, int xf, int yf, int xs, int ys,
                                          int rad, int color, int addr);
        command_t c;
        c.kind  = k;
        c.xf    = 16'(xf);
        c.yf    = 16'(yf);
        c.xs    = 16'(xs);
        c.ys    = 16'(ys);
        c.rad   = 16'(rad);
        c.color = 16'(color);
        c.addr  = 13'(addr);
        return c;
    endfunction

    // Coordinate near the screen, with a rare full-range value.
    function automatic int near_coord(int span);
        if ($urandom_range(99) < 4)
            return int'($signed(16'($urandom)));
        return $urandom_range(span + 24) - 12;
    endfunction

    function automatic command_t random_cmd();
        command_t c;
        int p;
        int x0;
        int y0;
        c = make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0);
        c.xf    = 16'($urandom);
        c.yf    = 16'($urandom);
        c.xs    = 16'($urandom);
        c.ys    = 16'($urandom);
        c.rad   = 16'($urandom);
        c.color = 16'($urandom);
        c.addr  = 13'($urandom);
        p = $urandom_range(999);
        if (p < 7)
            c.kind = KIND_CLEAR;
        else if (p < 12)
            c.kind = KIND_DARK;
        else if (p < 18)
            c.kind = KIND_INVERT;
        else if (p < 110)
        begin
            c.kind = KIND_COLOR;
            if ($urandom_range(1))
                c.color = COLOR_BLACK;
        end
        else if (p < 310)
        begin
            c.kind = KIND_PIXEL;
            if ($urandom_range(9) != 0)
            begin
                c.xf = 16'(near_coord(511));
                c.yf = 16'(near_coord(255));
            end
        end
        else if (p < 510)
        begin
            // Short lines around the screen, some of them vertical or horizontal.
            c.kind = KIND_LINE;
            x0 = $urandom_range(535) - 12;
            y0 = $urandom_range(279) - 12;
            c.xf = 16'(x0);
            c.yf = 16'(y0);
            c.xs = 16'(x0 + $urandom_range(80) - 40);
            c.ys = 16'(y0 + $urandom_range(80) - 40);
            if ($urandom_range(5) == 0)
                c.xs = c.xf;
            else if ($urandom_range(5) == 0)
                c.ys = c.yf;
        end
        else if (p < 630)
        begin
            c.kind = KIND_RECT;
            c.xf = 16'(near_coord(511));
            c.xs = 16'(near_coord(511));
            y0 = $urandom_range(279) - 12;
            c.yf = 16'(y0);
            c.ys = 16'(y0 + $urandom_range(16) - 3);
        end
        else if (p < 730)
        begin
            c.kind = KIND_CIRCLE;
            c.xf = 16'(near_coord(511));
            c.yf = 16'(near_coord(255));
            if ($urandom_range(9) != 0)
                c.rad = 16'($urandom_range(20) - 2);
            else if ($urandom_range(3) == 0)
                c.rad = 16'($urandom_range(181, 150));
        end
        else if (p < 970)
            c.kind = KIND_READ;
        else
            c.kind = 4'($urandom_range(15, 9));
        return c;
    endfunction

    initial
    begin
        command_t directed [$];
        rst_n          = 1'b0;
        steady_mode    = 1'b0;
        sent_count     = 0;
        idle_cycles    = 0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.kind    = KIND_CLEAR;
        cmd_ch.x_first = '0;
        cmd_ch.y_first = '0;
        cmd_ch.x_second = '0;
        cmd_ch.y_second = '0;
        cmd_ch.radius  = '0;
        cmd_ch.color_value = '0;
        cmd_ch.word_address = '0;
        res_ch.ready   = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: screen corners, off-screen pixels, every command and edge case.
        directed.push_back(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 8191));
        directed.push_back(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(KIND_PIXEL, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(KIND_PIXEL, 511, 255, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(KIND_PIXEL, -1, 512, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(KIND_PIXEL, -32768, 32767, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 8191));
        directed.push_back(make_cmd(KIND_LINE, 10, 40, 10, 5, 0, 0, 0));
        directed.push_back(make_cmd(KIND_LINE, 600, 7, -20, 7, 0, 0, 0));
        directed.push_back(make_cmd(KIND_LINE, 30, 60, 5, 20, 0, 0, 0));
        directed.push_back(make_cmd(KIND_LINE, 5, 100, 40, 90, 0, 0, 0));
        directed.push_back(make_cmd(KIND_LINE, -32768, -32768, 32767, 32767, 0, 0, 0));
        directed.push_back(make_cmd(KIND_RECT, 300, 10, 200, 14, 0, 0, 0));
        directed.push_back(make_cmd(KIND_RECT, 20, 30, 40, 29, 0, 0, 0));
        directed.push_back(make_cmd(KIND_RECT, 32767, 250, -32768, 300, 0, 0, 0));
        directed.push_back(make_cmd(KIND_CIRCLE, 256, 128, 0, 0, 181, 0, 0));
        directed.push_back(make_cmd(KIND_CIRCLE, 100, 100, 0, 0, 182, 0, 0));
        directed.push_back(make_cmd(KIND_CIRCLE, 100, 100, 0, 0, -5, 0, 0));
        directed.push_back(make_cmd(KIND_CIRCLE, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(KIND_COLOR, 0, 0, 0, 0, 0, 32767, 0));
        directed.push_back(make_cmd(KIND_PIXEL, 256, 128, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(KIND_INVERT, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 4104));
        directed.push_back(make_cmd(KIND_DARK, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(4'd15, -1, -1, -1, -1, -1, -1, 8191));
        foreach (directed[i])
            send(directed[i]);

        // Random commands, with stretches of steady traffic.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                steady_mode = ($urandom_range(2) == 0);
            send(random_cmd());
        end
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        steady_mode = 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Sent %0d commands: directed corner and edge cases, then random", sent_count);
        $display("pixels, lines, rectangles, circles, fills, color changes and reads.");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
